>>> src/utf8_stream_decoder_unit_defines.svh
// Assertion macros for the UTF-8 stream decoder unit.
// Depends on nothing; included by the top level.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define UTF8_SD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTF8_SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/utf8_sd_pkg.sv
// Shared types, constants and decode functions of the UTF-8 stream decoder.
// Depends on nothing; used by every other file but the defines header.
package utf8_sd_pkg;

    localparam int unsigned OUTQ_DEPTH = 4;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 31;

    localparam logic [UNIT_W-1:0] QMARK     = 31'h0000_003F;
    localparam logic [UNIT_W-1:0] BMP_MAX   = 31'h0000_FFFF;
    localparam logic [UNIT_W-1:0] SUPP_BASE = 31'h0001_0000;
    localparam logic [15:0]       HI_SURR   = 16'hD800;
    localparam logic [15:0]       LO_SURR   = 16'hDC00;

    typedef enum logic [1:0] {
        LK_ASCII,
        LK_INVALID,
        LK_LEAD
    } t_lead_kind;

    typedef struct packed {
        t_lead_kind kind;
        logic [2:0] cnt;
        logic [4:0] pay;
    } t_lead;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              run_last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic in_valid;
        logic advance;
    } t_core_status;

    function automatic t_lead decode_lead(input logic [BYTE_W-1:0] b);
        t_lead l;
        l.kind = LK_LEAD;
        l.cnt  = 3'd0;
        l.pay  = 5'd0;
        if (!b[7]) begin
            l.kind = LK_ASCII;
        end else if (b[7:5] == 3'b110) begin
            l.cnt = 3'd1;
            l.pay = b[4:0];
        end else if (b[7:4] == 4'b1110) begin
            l.cnt = 3'd2;
            l.pay = {1'b0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            l.cnt = 3'd3;
            l.pay = {2'b0, b[2:0]};
        end else if (b[7:2] == 6'b111110) begin
            l.cnt = 3'd4;
            l.pay = {3'b0, b[1:0]};
        end else if (b[7:1] == 7'b1111110) begin
            l.cnt = 3'd5;
            l.pay = {4'b0, b[0]};
        end else begin
            l.kind = LK_INVALID;
        end
        return l;
    endfunction

    function automatic logic [UNIT_W-1:0] min_for_len(input logic [2:0] len);
        logic [UNIT_W-1:0] m;
        case (len)
            3'd2:    m = 31'h0000_0080;
            3'd3:    m = 31'h0000_0800;
            3'd4:    m = 31'h0001_0000;
            3'd5:    m = 31'h0020_0000;
            3'd6:    m = 31'h0400_0000;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> src/utf8_sd_if.sv
// Valid/ready channel interfaces for text bytes in and code units out.
// Depends on utf8_sd_pkg for field widths.
interface utf8_sd_byte_if;
    logic                             valid;
    logic                             ready;
    logic [utf8_sd_pkg::BYTE_W-1:0]   text_byte;
    logic                             end_of_text;
    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface utf8_sd_unit_if;
    logic                             valid;
    logic                             ready;
    logic [utf8_sd_pkg::UNIT_W-1:0]   code_unit;
    logic                             run_last;
    modport source (output valid, code_unit, run_last, input ready);
    modport sink   (input valid, code_unit, run_last, output ready);
endinterface

>>> src/utf8_sd_core.sv
// Input register, sequence state and single-pass decode of one byte.
// Depends on utf8_sd_pkg and utf8_sd_byte_if.
module utf8_sd_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_wdata,
    utf8_sd_byte_if.sink             i_text,
    input  logic                     i_can_push2,
    output utf8_sd_pkg::t_push       o_push,
    output utf8_sd_pkg::t_core_status o_status
);

    logic                            r_utf16;
    logic                            r_in_valid;
    logic [utf8_sd_pkg::BYTE_W-1:0]  r_byte;
    logic                            r_eot;
    logic [2:0]                      r_left;
    logic [2:0]                      r_len;
    logic [utf8_sd_pkg::UNIT_W-1:0]  r_acc;

    logic [2:0]                      n_left;
    logic [2:0]                      n_len;
    logic [utf8_sd_pkg::UNIT_W-1:0]  n_acc;

    logic                            advance;
    utf8_sd_pkg::t_push              push;
    utf8_sd_pkg::t_lead              lead;
    logic [utf8_sd_pkg::UNIT_W-1:0]  acc_shift;
    logic [utf8_sd_pkg::UNIT_W-1:0]  fin_v;
    logic [utf8_sd_pkg::UNIT_W-1:0]  w;
    logic [utf8_sd_pkg::UNIT_W-1:0]  partial;
    logic [utf8_sd_pkg::UNIT_W-1:0]  start_val;
    logic                            is_cont;

    assign advance      = r_in_valid && i_can_push2;
    assign i_text.ready = !r_in_valid || advance;

    always_comb begin
        lead      = utf8_sd_pkg::decode_lead(r_byte);
        is_cont   = (r_byte[7:6] == 2'b10);
        acc_shift = {r_acc[utf8_sd_pkg::UNIT_W-7:0], r_byte[5:0]};
        fin_v     = (acc_shift < utf8_sd_pkg::min_for_len(r_len)) ? utf8_sd_pkg::QMARK
                                                                   : acc_shift;
        w         = fin_v - utf8_sd_pkg::SUPP_BASE;
        partial   = r_utf16 ? {15'b0, r_acc[15:0]} : r_acc;
        start_val = (lead.kind == utf8_sd_pkg::LK_ASCII) ? {23'b0, r_byte}
                                                          : utf8_sd_pkg::QMARK;
    end

    always_comb begin
        n_left = r_left;
        n_len  = r_len;
        n_acc  = r_acc;
        push   = '0;
        if (r_left != 3'd0 && is_cont) begin
            n_acc  = acc_shift;
            n_left = r_left - 3'd1;
            if (r_left == 3'd1) begin
                n_len = 3'd0;
                n_acc = '0;
                if (r_utf16 && fin_v > utf8_sd_pkg::BMP_MAX) begin
                    push.count          = 2'd2;
                    push.res0.code_unit = {15'b0, utf8_sd_pkg::HI_SURR | {6'b0, w[19:10]}};
                    push.res1.code_unit = {15'b0, utf8_sd_pkg::LO_SURR | {6'b0, w[9:0]}};
                end else begin
                    push.count          = 2'd1;
                    push.res0.code_unit = fin_v;
                end
            end
        end else begin
            if (r_left != 3'd0) begin
                push.count          = 2'd1;
                push.res0.code_unit = partial;
                n_left = 3'd0;
                n_len  = 3'd0;
                n_acc  = '0;
            end
            if (lead.kind == utf8_sd_pkg::LK_LEAD) begin
                n_left = lead.cnt;
                n_len  = lead.cnt + 3'd1;
                n_acc  = {26'b0, lead.pay};
            end else if (push.count == 2'd1) begin
                push.count          = 2'd2;
                push.res1.code_unit = start_val;
            end else begin
                push.count          = 2'd1;
                push.res0.code_unit = start_val;
            end
        end
        if (r_eot) begin
            n_left = 3'd0;
            n_len  = 3'd0;
            n_acc  = '0;
        end
        push.res0.run_last = (push.count == 2'd1);
        push.res1.run_last = (push.count == 2'd2);
        if (!advance) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf16    <= 1'b0;
            r_in_valid <= 1'b0;
            r_left     <= '0;
            r_len      <= '0;
            r_acc      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_utf16 <= i_cfg_wdata;
            end
            if (i_text.ready) begin
                r_in_valid <= i_text.valid;
            end
            if (advance) begin
                r_left <= n_left;
                r_len  <= n_len;
                r_acc  <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_byte <= i_text.text_byte;
            r_eot  <= i_text.end_of_text;
        end
    end

    assign o_push            = push;
    assign o_status.in_valid = r_in_valid;
    assign o_status.advance  = advance;

endmodule

>>> src/utf8_sd_outq.sv
// Result queue: takes up to two code units per cycle, delivers one.
// Depends on utf8_sd_pkg and utf8_sd_unit_if.
module utf8_sd_outq #(
    parameter int unsigned DEPTH = utf8_sd_pkg::OUTQ_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utf8_sd_pkg::t_push i_push,
    output logic               o_can_push2,
    utf8_sd_unit_if.source     o_unit
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    utf8_sd_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;

    logic [PTR_W-1:0]     n_wr_ptr;
    logic [PTR_W-1:0]     n_rd_ptr;
    logic [CNT_W-1:0]     n_count;
    logic [PTR_W-1:0]     wr_ptr1;
    logic                 pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop              = o_unit.valid && o_unit.ready;
    assign o_unit.valid     = (r_count != '0);
    assign o_unit.code_unit = r_mem[r_rd_ptr].code_unit;
    assign o_unit.run_last  = r_mem[r_rd_ptr].run_last;
    assign o_can_push2      = (r_count <= CNT_W'(DEPTH - 2));
    assign wr_ptr1          = ptr_inc(r_wr_ptr);

    always_comb begin
        case (i_push.count)
            2'd1:    n_wr_ptr = wr_ptr1;
            2'd2:    n_wr_ptr = ptr_inc(wr_ptr1);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

endmodule

>>> src/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder, one text byte per cycle. A byte is accepted into an
// input register and decoded combinationally against the pending sequence
// (2 to 6 byte forms), giving zero, one or two code units into a result queue;
// the first unit of a byte passes the input register and then the result
// queue before it is offered on the output. The rate is one byte per cycle as
// long as the output side takes one unit per cycle; a byte that yields two
// units (a surrogate pair, or a cut-off partial plus a new start) needs two
// output transfers, and decode holds whenever the result queue has fewer than
// two free entries. Depends on utf8_sd_pkg, the channel interfaces,
// utf8_sd_core, utf8_sd_outq and the defines header.
`include "utf8_stream_decoder_unit_defines.svh"

module utf8_stream_decoder_unit #(
    parameter int unsigned OUTQ_DEPTH = utf8_sd_pkg::OUTQ_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    utf8_sd_byte_if.sink   i_text,
    utf8_sd_unit_if.source o_unit
);

    utf8_sd_pkg::t_push        push;
    utf8_sd_pkg::t_core_status core_status;
    logic                      can_push2;

    utf8_sd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_text      (i_text),
        .i_can_push2 (can_push2),
        .o_push      (push),
        .o_status    (core_status)
    );

    utf8_sd_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_can_push2 (can_push2),
        .o_unit      (o_unit)
    );

    `UTF8_SD_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, push.count != 2'd0, can_push2 && core_status.advance, "result push without queue room")
    `UTF8_SD_ASSERT_NOW(a_run_last_order, i_clk, i_rst_n, push.count == 2'd2, !push.res0.run_last && push.res1.run_last, "run_last misplaced on a two-unit transaction")
    `UTF8_SD_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_text.valid && i_text.ready, core_status.in_valid, "accepted byte not held in input register")

endmodule
